### sv/smpq_pkg.sv
// Package for the sorted minimum priority queue: capacity, widths,
// operation codes and the structs passed between the top level and its cells.
// Depends on nothing.
package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    // What one cell shows its neighbors: its entry and whether an insert lands at or before it.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] val;
        logic                    ins;
    } cell_link_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic                    ins_en;
        logic                    rem_en;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

### sv/sorted_min_priority_queue_core.sv
// Sorted minimum priority queue: a row of smpq_cell instances, the entry count
// and the result register. Depends on smpq_pkg and smpq_cell.
//
// Usage: the input channel (s_valid, s_ready, s_func, s_value) takes one
// operation per beat: insert s_value, or remove the smallest stored value.
// Every input beat gives exactly one result beat on the output channel
// (m_valid, m_ready, m_removed_value, m_removed_valid, m_entry_count,
// m_insert_dropped). The result appears in the cycle after the input beat is
// taken. An item is taken every cycle while the receiver does not stall: all
// cells compare the new value with their own entry in parallel and shift in
// the same cycle.
// An insert into a full queue is dropped and flagged; a remove from an empty
// queue reports no value and a zero removed value.
// Reset empties the queue and clears the result valid flag. When the receiver
// stalls, the result is held and s_ready stays low until the result is taken,
// or rises in the same cycle that m_ready takes it.
module sorted_min_priority_queue_core
    import smpq_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic signed [VAL_W-1:0]     s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [VAL_W-1:0]     m_removed_value,
    output logic                        m_removed_valid,
    output logic [OUT_CNT_W-1:0]        m_entry_count,
    output logic                        m_insert_dropped
);

    cell_link_t                   links [CAPACITY];
    cell_link_t                   left_links [CAPACITY];
    cell_link_t                   right_links [CAPACITY];
    cell_cmd_t                    cmd;
    logic                         accept;
    logic                         full;
    logic                         empty;
    logic                         is_insert;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [CNT_W+OUT_CNT_W-1:0]   count_wide;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic signed [VAL_W-1:0]      removed_value_reg;
    logic signed [VAL_W-1:0]      removed_value_next;
    logic                         removed_valid_reg;
    logic                         removed_valid_next;
    logic [OUT_CNT_W-1:0]         entry_count_reg;
    logic [OUT_CNT_W-1:0]         entry_count_next;
    logic                         dropped_reg;
    logic                         dropped_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign is_insert = (func_t'(s_func) == FUNC_INSERT);

    assign cmd.ins_en = accept && is_insert && !full;
    assign cmd.rem_en = accept && !is_insert && !empty;
    assign cmd.value  = s_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_links[i] = '{vld: 1'b0, val: '0, ins: 1'b0};
        end else begin : g_mid
            assign left_links[i] = links[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_links[i] = '{vld: 1'b0, val: '0, ins: 1'b0};
        end else begin : g_inner
            assign right_links[i] = links[i+1];
        end
        smpq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .from_left  (left_links[i]),
            .from_right (right_links[i]),
            .link       (links[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.rem_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_wide = {{OUT_CNT_W{1'b0}}, count_next};

    always_comb begin
        m_valid_next       = m_valid_reg;
        removed_value_next = removed_value_reg;
        removed_valid_next = removed_valid_reg;
        entry_count_next   = entry_count_reg;
        dropped_next       = dropped_reg;
        if (accept) begin
            m_valid_next       = 1'b1;
            removed_value_next = cmd.rem_en ? links[0].val : '0;
            removed_valid_next = cmd.rem_en;
            entry_count_next   = count_wide[OUT_CNT_W-1:0];
            dropped_next       = is_insert && full;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        removed_value_reg <= removed_value_next;
        removed_valid_reg <= removed_valid_next;
        entry_count_reg   <= entry_count_next;
        dropped_reg       <= dropped_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_removed_value  = removed_value_reg;
    assign m_removed_valid  = removed_valid_reg;
    assign m_entry_count    = entry_count_reg;
    assign m_insert_dropped = dropped_reg;

endmodule

### sv/smpq_cell.sv
// One cell of the sorted row: holds one entry and its valid flag.
// Takes the inserted value, its left neighbor's entry or its right neighbor's entry.
// Depends on smpq_pkg.
module smpq_cell
    import smpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_cmd_t  cmd,
    input  cell_link_t from_left,
    input  cell_link_t from_right,
    output cell_link_t link
);

    logic                    vld_reg;
    logic                    vld_next;
    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    ins_here;

    assign ins_here = !vld_reg || (cmd.value < val_reg);

    always_comb begin
        vld_next = vld_reg;
        val_next = val_reg;
        if (cmd.ins_en) begin
            if (from_left.ins) begin
                vld_next = from_left.vld;
                val_next = from_left.val;
            end else if (ins_here) begin
                vld_next = 1'b1;
                val_next = cmd.value;
            end
        end else if (cmd.rem_en) begin
            vld_next = from_right.vld;
            val_next = from_right.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        val_reg <= val_next;
    end

    assign link.vld = vld_reg;
    assign link.val = val_reg;
    assign link.ins = ins_here;

endmodule

### sv/smpq_checker.sv
// Port-level checks for sorted_min_priority_queue_core, attached by bind.
// Depends on smpq_pkg.
module smpq_checker
    import smpq_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [VAL_W-1:0] m_removed_value,
    input logic                    m_removed_valid,
    input logic [OUT_CNT_W-1:0]    m_entry_count,
    input logic                    m_insert_dropped
);

    localparam int FullCountWide = CAPACITY;
    localparam logic [OUT_CNT_W-1:0] FULL_COUNT = FullCountWide[OUT_CNT_W-1:0];

    // A stalled result beat stays valid and keeps its removed value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_removed_value))
        else $error("result beat changed while stalled");

    // Every accepted input beat gives a result beat in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result beat after an accepted input beat");

    // A dropped insert means the queue is full and nothing was removed.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_insert_dropped |-> m_entry_count == FULL_COUNT && !m_removed_valid)
        else $error("dropped insert without a full queue");

    // Without a removal the removed value reads zero.
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_removed_valid |-> m_removed_value == '0)
        else $error("removed value not zero without a removal");

endmodule

bind sorted_min_priority_queue_core smpq_checker u_smpq_checker (.*);
